@@ design/sra_pkg.sv @@
// Shared types and constants for the skyline rectangle allocator.
// No dependencies; every other design file refers to this package by scoped names.
package sra_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int MAX_SIDE     = 4096;
  localparam int DIM_W        = 13;
  localparam int POS_W        = 12;
  localparam int AREA_W       = 25;

  localparam logic [DIM_W-1:0]  SIDE_MAX  = DIM_W'(MAX_SIDE);
  localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};
  localparam logic [DIM_W-1:0]  RST_SIDE  = 13'd512;
  localparam logic [DIM_W-1:0]  RST_SPAN  = 13'd510;

  // configuration register indexes
  localparam logic CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic CFG_ATLAS_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  // one skyline segment
  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] span;
  } seg_t;

  // segment travelling down the fit stream
  typedef struct packed {
    logic v;
    seg_t seg;
  } stream_t;

  // fit outcome of one start position
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] sx;
    logic [DIM_W-1:0] ssp;
  } fit_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_LOAD,
    OP_STEP,
    OP_SHIFT,
    OP_INSERT,
    OP_TRIM,
    OP_MERGE
  } cell_op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t         op;
    logic             kill;
    logic [DIM_W-1:0] req_w;
    logic [DIM_W-1:0] req_h;
    logic [DIM_W-1:0] atlas_w;
    logic [DIM_W-1:0] atlas_h;
    logic [DIM_W-1:0] span0;
    seg_t             new_seg;
  } cell_ctrl_t;

endpackage

@@ design/sra_if.sv @@
// Request and result channel interfaces for the skyline allocator.
// Depends on sra_pkg for field widths.
interface sra_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [sra_pkg::DIM_W-1:0]   req_width;
  logic [sra_pkg::DIM_W-1:0]   req_height;

  modport source (output valid, mode, req_width, req_height, input ready);
  modport sink   (input valid, mode, req_width, req_height, output ready);
endinterface

interface sra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [sra_pkg::POS_W-1:0]   region_x;
  logic [sra_pkg::POS_W-1:0]   region_y;
  logic [sra_pkg::AREA_W-1:0]  used_area;

  modport source (output valid, status, region_x, region_y, used_area, input ready);
  modport sink   (input valid, status, region_x, region_y, used_area, output ready);
endinterface

@@ design/skyline_rect_allocator.sv @@
// Skyline rectangle allocator top level: sequencer, configuration and the row of cells.
// Depends on sra_pkg, sra_if (sra_req_if, sra_rsp_if) and sra_cell.
//
//  channel | dir | handshake        | payload
//  alloc   | in  | valid / ready    | mode, req_width, req_height
//  result  | out | valid / ready    | status, region_x, region_y, used_area
//  config  | in  | wr_en            | wr_index, wr_data
//
// Clear and zero-size requests finish in S_START. An allocate runs the fit
// stream, the best-start pick and a decide step, then trims covered segments,
// merges equal tops and updates the area: the fit stream and the result
// readout each move one segment per cycle through the cell row.
// One request is worked on at a time; a finished result waits in the output
// register while the next request is taken. Reset is synchronous and restores
// the 512x512 atlas with a single empty segment.
module skyline_rect_allocator #(
  parameter int MAX_SEGMENTS = sra_pkg::MAX_SEGMENTS
) (
  input  logic                       clk,
  input  logic                       rst,
  sra_req_if.sink                    alloc,
  sra_rsp_if.source                  result,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [sra_pkg::DIM_W-1:0]  wr_data
);
  localparam int SEGS = MAX_SEGMENTS;
  localparam int CW   = $clog2(SEGS+1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_FIT, S_PICK, S_DECIDE, S_TRIM, S_MERGE, S_AREA
  } state_t;

  state_t state;
  logic   busy_out;   // result computed, waiting for the output register

  logic [12:0] atlas_w, atlas_h;
  logic        mode;
  logic [12:0] w, h;
  logic [CW-1:0] count, ptr, k, best;
  logic        found;
  logic [13:0] best_end;
  logic [12:0] best_span, best_x, best_y;
  logic [25:0] prod;
  logic [24:0] area;
  sra_pkg::status_t pend_status;
  logic [11:0] pend_x, pend_y;

  sra_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0]       cptr;
  sra_pkg::seg_t       seg_v  [SEGS];
  sra_pkg::stream_t    strm_v [SEGS];
  sra_pkg::fit_t       res_v  [SEGS];
  logic [SEGS-1:0]     rm_v, mg_v;

  logic [13:0] head_end;
  logic        better;
  logic [26:0] area_sum;
  logic        can_trim, can_merge;

  // configuration registers, saturating at the largest side
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w <= sra_pkg::RST_SIDE;
      atlas_h <= sra_pkg::RST_SIDE;
    end else if (wr_en) begin
      unique case (wr_index)
        sra_pkg::CFG_ATLAS_WIDTH:
          atlas_w <= (wr_data > sra_pkg::SIDE_MAX) ? sra_pkg::SIDE_MAX : wr_data;
        default:
          atlas_h <= (wr_data > sra_pkg::SIDE_MAX) ? sra_pkg::SIDE_MAX : wr_data;
      endcase
    end
  end

  assign alloc.ready = (state == S_IDLE) && !busy_out;

  // best-start comparison on the head of the result chain
  assign head_end = {1'b0, res_v[0].y} + {1'b0, h};
  assign better   = res_v[0].ok &&
                    (!found || head_end < best_end ||
                     (head_end == best_end && res_v[0].ssp != '0 &&
                      res_v[0].ssp < best_span));
  assign area_sum  = {2'b00, area} + {1'b0, prod};
  assign can_trim  = ptr < count;
  assign can_merge = ({1'b0, ptr} + 1'b1) < {1'b0, count};

  // cell control broadcast
  always_comb begin
    ctrl.op      = sra_pkg::OP_HOLD;
    ctrl.kill    = 1'b0;
    ctrl.req_w   = w;
    ctrl.req_h   = h;
    ctrl.atlas_w = atlas_w;
    ctrl.atlas_h = atlas_h;
    ctrl.span0   = (atlas_w > 13'd2) ? atlas_w - 13'd2 : '0;
    ctrl.new_seg = '{x: best_x, top: best_y + h, span: w};
    cptr         = (state == S_DECIDE) ? best : ptr;
    unique case (state)
      S_START: begin
        if (mode) ctrl.op = sra_pkg::OP_CLEAR;
        else if (w != '0 && h != '0) ctrl.op = sra_pkg::OP_LOAD;
      end
      S_FIT:    ctrl.op = sra_pkg::OP_STEP;
      S_PICK:   ctrl.op = sra_pkg::OP_SHIFT;
      S_DECIDE: if (found && count < CW'(SEGS)) ctrl.op = sra_pkg::OP_INSERT;
      S_TRIM: begin
        if (can_trim) begin
          ctrl.op   = sra_pkg::OP_TRIM;
          ctrl.kill = |rm_v;
        end
      end
      S_MERGE: begin
        if (can_merge) begin
          ctrl.op   = sra_pkg::OP_MERGE;
          ctrl.kill = |mg_v;
        end
      end
      default: begin
      end
    endcase
  end

  // row of cells
  for (genvar i = 0; i < SEGS; i++) begin : g_cell
    sra_pkg::seg_t    lseg, rseg;
    sra_pkg::stream_t sin;
    sra_pkg::fit_t    rin;
    if (i == 0) begin : g_first
      assign lseg = '0;
    end else begin : g_mid_l
      assign lseg = seg_v[i-1];
    end
    if (i == SEGS-1) begin : g_last
      assign rseg = '0;
      assign sin  = '0;
      assign rin  = '0;
    end else begin : g_mid_r
      assign rseg = seg_v[i+1];
      assign sin  = strm_v[i+1];
      assign rin  = res_v[i+1];
    end
    sra_cell #(.SEGS(SEGS), .IDX(i)) u_cell (
      .clk, .rst, .ctrl, .ptr(cptr), .count,
      .left_seg(lseg), .right_seg(rseg), .strm_in(sin), .res_in(rin),
      .seg_out(seg_v[i]), .strm_out(strm_v[i]), .res_out(res_v[i]),
      .rm_req(rm_v[i]), .mg_req(mg_v[i])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy_out     <= 1'b0;
      count        <= CW'(1);
      area         <= '0;
      found        <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (busy_out && (!result.valid || result.ready)) begin
        result.valid     <= 1'b1;
        result.status    <= pend_status;
        result.region_x  <= pend_x;
        result.region_y  <= pend_y;
        result.used_area <= area;
        busy_out         <= 1'b0;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (alloc.valid && alloc.ready) begin
            mode  <= alloc.mode;
            w     <= alloc.req_width;
            h     <= alloc.req_height;
            state <= S_START;
          end
        end
        S_START: begin
          pend_x <= '0;
          pend_y <= '0;
          prod   <= w * h;
          found  <= 1'b0;
          k      <= '0;
          if (mode) begin
            count       <= CW'(1);
            area        <= '0;
            pend_status <= sra_pkg::ST_CLEARED;
            busy_out    <= 1'b1;
            state       <= S_IDLE;
          end else if (w == '0 || h == '0) begin
            pend_status <= sra_pkg::ST_NO_ROOM;
            busy_out    <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (k == CW'(SEGS-1)) begin
            k     <= '0;
            state <= S_PICK;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_PICK: begin
          if (better) begin
            found     <= 1'b1;
            best      <= k;
            best_end  <= head_end;
            best_span <= res_v[0].ssp;
            best_x    <= res_v[0].sx;
            best_y    <= res_v[0].y;
          end
          k <= k + 1'b1;
          if (k == CW'(SEGS-1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!found) begin
            pend_status <= sra_pkg::ST_NO_ROOM;
            busy_out    <= 1'b1;
            state       <= S_IDLE;
          end else if (count >= CW'(SEGS)) begin
            pend_status <= sra_pkg::ST_FULL;
            busy_out    <= 1'b1;
            state       <= S_IDLE;
          end else begin
            count <= count + 1'b1;
            ptr   <= best + 1'b1;
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (can_trim && |rm_v) begin
            count <= count - 1'b1;
          end else begin
            ptr   <= '0;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (!can_merge) state <= S_AREA;
          else if (|mg_v) count <= count - 1'b1;
          else ptr <= ptr + 1'b1;
        end
        S_AREA: begin
          area        <= (area_sum > {2'b00, sra_pkg::AREA_MAX}) ?
                         sra_pkg::AREA_MAX : area_sum[24:0];
          pend_status <= sra_pkg::ST_PLACED;
          pend_x      <= best_x[11:0];
          pend_y      <= best_y[11:0];
          busy_out    <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CW'(SEGS))
    else $error("segment count out of range");

  a_one_edit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rm_v) && $onehot0(mg_v))
    else $error("more than one cell asks to remove or merge");

  a_clear_area: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == sra_pkg::ST_CLEARED |-> result.used_area == '0)
    else $error("cleared result with nonzero area");

  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    busy_out |-> state == S_IDLE)
    else $error("pending result while sequencer busy");

endmodule

@@ design/sra_cell.sv @@
// One skyline cell: holds a segment, runs the fit test for its start position,
// and shifts segments, fit results and stream data to and from its neighbors. Uses sra_pkg.
module sra_cell #(
  parameter int SEGS = sra_pkg::MAX_SEGMENTS,
  parameter int IDX  = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sra_pkg::cell_ctrl_t             ctrl,
  input  logic [$clog2(SEGS+1)-1:0]       ptr,
  input  logic [$clog2(SEGS+1)-1:0]       count,
  input  sra_pkg::seg_t                   left_seg,
  input  sra_pkg::seg_t                   right_seg,
  input  sra_pkg::stream_t                strm_in,
  input  sra_pkg::fit_t                   res_in,
  output sra_pkg::seg_t                   seg_out,
  output sra_pkg::stream_t                strm_out,
  output sra_pkg::fit_t                   res_out,
  output logic                            rm_req,
  output logic                            mg_req
);
  localparam int CW = $clog2(SEGS+1);
  localparam logic [CW-1:0] MY = CW'(IDX);

  sra_pkg::seg_t    seg;
  sra_pkg::stream_t strm;
  logic             done, fail;
  logic signed [14:0] left;
  logic [12:0]      y, sx, ssp;

  logic [12:0]        ymax;
  logic [13:0]        yend, xend, prev_end, shrink;
  logic signed [14:0] left_n;
  logic               overlap;

  // fit step arithmetic
  assign ymax   = (strm.seg.top > y) ? strm.seg.top : y;
  assign yend   = {1'b0, ymax} + {1'b0, ctrl.req_h};
  assign left_n = left - $signed({2'b00, strm.seg.span});
  assign xend   = {1'b0, seg.x} + {1'b0, ctrl.req_w};

  // overlap with the left neighbor after an insert
  assign prev_end = {1'b0, left_seg.x} + {1'b0, left_seg.span};
  assign overlap  = {1'b0, seg.x} < prev_end;
  assign shrink   = prev_end - {1'b0, seg.x};

  assign rm_req = (ctrl.op == sra_pkg::OP_TRIM) && (ptr == MY) && overlap &&
                  ({1'b0, seg.span} <= shrink);
  assign mg_req = (ctrl.op == sra_pkg::OP_MERGE) && (ptr == MY) &&
                  (seg.top == right_seg.top);

  assign seg_out  = seg;
  assign strm_out = strm;
  assign res_out  = '{ok: done && !fail, y: y, sx: sx, ssp: ssp};

  always_ff @(posedge clk) begin
    if (rst) begin
      seg  <= (IDX == 0) ?
              sra_pkg::seg_t'{x: 13'd1, top: 13'd1, span: sra_pkg::RST_SPAN} : '0;
      strm <= '0;
      done <= 1'b0;
      fail <= 1'b0;
      left <= '0;
      y    <= '0;
      sx   <= '0;
      ssp  <= '0;
    end else begin
      unique case (ctrl.op)
        sra_pkg::OP_CLEAR: begin
          seg <= (IDX == 0) ?
                 sra_pkg::seg_t'{x: 13'd1, top: 13'd1, span: ctrl.span0} : '0;
        end
        sra_pkg::OP_LOAD: begin
          strm <= '{v: MY < count, seg: seg};
          left <= $signed({2'b00, ctrl.req_w});
          y    <= seg.top;
          sx   <= seg.x;
          ssp  <= seg.span;
          fail <= xend >= {1'b0, ctrl.atlas_w};
          done <= 1'b0;
        end
        sra_pkg::OP_STEP: begin
          strm <= strm_in;
          if (!done && !fail) begin
            if (!strm.v) begin
              fail <= 1'b1;
            end else begin
              y <= ymax;
              if (yend >= {1'b0, ctrl.atlas_h}) begin
                fail <= 1'b1;
              end else begin
                left <= left_n;
                if (left_n <= 0) done <= 1'b1;
              end
            end
          end
        end
        sra_pkg::OP_SHIFT: begin
          done <= res_in.ok;
          fail <= 1'b0;
          y    <= res_in.y;
          sx   <= res_in.sx;
          ssp  <= res_in.ssp;
        end
        sra_pkg::OP_INSERT: begin
          if (MY > ptr) seg <= left_seg;
          else if (MY == ptr) seg <= ctrl.new_seg;
        end
        sra_pkg::OP_TRIM: begin
          if (ctrl.kill) begin
            if (MY >= ptr) seg <= right_seg;
          end else if (MY == ptr && overlap) begin
            seg.x    <= prev_end[12:0];
            seg.span <= seg.span - shrink[12:0];
          end
        end
        sra_pkg::OP_MERGE: begin
          if (ctrl.kill) begin
            if (MY == ptr) seg.span <= seg.span + right_seg.span;
            else if (MY > ptr) seg <= right_seg;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

@@ verif/sra_tb_if.sv @@
`timescale 1ns / 100ps
// Testbench package for the allocator checker: the expected-result type, built
// on the field widths and status type of sra_pkg.
package sra_tb_pkg;
  import sra_pkg::*;

  // one expected result
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] region_x;
    logic [POS_W-1:0] region_y;
    logic [AREA_W-1:0] used_area;
  } placement_t;
endpackage

@@ verif/sra_checker.sv @@
`timescale 1ns / 100ps
// Checker for the skyline allocator: watches request, result and config ports,
// predicts each result with its own skyline model and compares field by field.
module sra_checker (
  input  logic                       clk,
  input  logic                       rst,
  sra_req_if.sink                    alloc,
  sra_rsp_if.sink                    result,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [sra_pkg::DIM_W-1:0]  wr_data,
  output int                         fail_count,
  output int                         pending
);
  import sra_pkg::*;
  import sra_tb_pkg::*;

  int sky_x[MAX_SEGMENTS];
  int sky_top[MAX_SEGMENTS];
  int sky_span[MAX_SEGMENTS];
  int sky_count;
  int area_sum;
  int atlas_w, atlas_h;
  placement_t expected_q[$];

  assign pending = expected_q.size();

  function automatic void clear_skyline();
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      sky_x[k] = 0;
      sky_top[k] = 0;
      sky_span[k] = 0;
    end
    sky_x[0] = 1;
    sky_top[0] = 1;
    sky_span[0] = (atlas_w - 2 > 0) ? atlas_w - 2 : 0;
    sky_count = 1;
    area_sum = 0;
  endfunction

  // top y for a rectangle placed at segment s, or -1
  function automatic int fit_top(int s, int w, int h);
    int y;
    int left;
    int i;
    left = w;
    i = s;
    if (sky_x[s] + w > atlas_w - 1) return -1;
    y = sky_top[s];
    while (left > 0) begin
      if (i >= sky_count) return -1;
      if (sky_top[i] > y) y = sky_top[i];
      if (y + h > atlas_h - 1) return -1;
      left -= sky_span[i];
      i++;
    end
    return y;
  endfunction

  function automatic void drop_segment(int idx);
    for (int k = idx; k + 1 < sky_count; k++) begin
      sky_x[k] = sky_x[k+1];
      sky_top[k] = sky_top[k+1];
      sky_span[k] = sky_span[k+1];
    end
    sky_count--;
    sky_x[sky_count] = 0;
    sky_top[sky_count] = 0;
    sky_span[sky_count] = 0;
  endfunction

  function automatic placement_t place_rect(logic mode, int w, int h);
    placement_t r;
    int best, best_end, best_span, best_y, best_x, y, i;
    longint total;
    r = '{status: ST_NO_ROOM, region_x: '0, region_y: '0, used_area: '0};
    best = -1;
    best_end = 0;
    best_span = 0;
    best_y = 0;
    best_x = 0;
    if (mode) begin
      clear_skyline();
      r.status = ST_CLEARED;
    end else if (w > 0 && h > 0) begin
      for (int s = 0; s < sky_count; s++) begin
        y = fit_top(s, w, h);
        if (y >= 0 && (best < 0 || y + h < best_end ||
            (y + h == best_end && sky_span[s] > 0 && sky_span[s] < best_span))) begin
          best = s;
          best_end = y + h;
          best_span = sky_span[s];
          best_y = y;
          best_x = sky_x[s];
        end
      end
      if (best >= 0 && sky_count >= MAX_SEGMENTS) begin
        r.status = ST_FULL;
      end else if (best >= 0) begin
        // insert the new top, trim what it covers, then merge equal tops
        for (int k = sky_count; k > best; k--) begin
          sky_x[k] = sky_x[k-1];
          sky_top[k] = sky_top[k-1];
          sky_span[k] = sky_span[k-1];
        end
        sky_x[best] = best_x;
        sky_top[best] = best_y + h;
        sky_span[best] = w;
        sky_count++;
        i = best + 1;
        while (i < sky_count) begin
          if (sky_x[i] < sky_x[i-1] + sky_span[i-1]) begin
            int shrink;
            shrink = sky_x[i-1] + sky_span[i-1] - sky_x[i];
            sky_x[i] += shrink;
            sky_span[i] -= shrink;
            if (sky_span[i] <= 0) begin
              drop_segment(i);
              continue;
            end
          end
          break;
        end
        i = 0;
        while (i + 1 < sky_count) begin
          if (sky_top[i] == sky_top[i+1]) begin
            sky_span[i] = (sky_span[i] + sky_span[i+1]) & 32'h1FFF;
            drop_segment(i + 1);
          end else begin
            i++;
          end
        end
        total = longint'(area_sum) + longint'(w) * longint'(h);
        area_sum = (total > longint'(AREA_MAX)) ? int'(AREA_MAX) : int'(total);
        r.status = ST_PLACED;
        r.region_x = best_x[POS_W-1:0];
        r.region_y = best_y[POS_W-1:0];
      end
    end
    r.used_area = area_sum[AREA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      atlas_w = RST_SIDE;
      atlas_h = RST_SIDE;
      clear_skyline();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (wr_en) begin
        int v;
        v = (wr_data > SIDE_MAX) ? MAX_SIDE : int'(wr_data);
        if (wr_index == CFG_ATLAS_WIDTH) atlas_w = v;
        else atlas_h = v;
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status=%0d x=%0d y=%0d area=%0d", $time,
                   result.status, result.region_x, result.region_y, result.used_area);
        end else begin
          placement_t e;
          e = expected_q.pop_front();
          if (result.status !== e.status || result.region_x !== e.region_x ||
              result.region_y !== e.region_y || result.used_area !== e.used_area) begin
            fail_count++;
            $display("%0t: mismatch exp st=%0d x=%0d y=%0d area=%0d got st=%0d x=%0d y=%0d area=%0d",
                     $time, e.status, e.region_x, e.region_y, e.used_area, result.status,
                     result.region_x, result.region_y, result.used_area);
          end
        end
      end
      if (alloc.valid && alloc.ready)
        expected_q.push_back(place_rect(alloc.mode, alloc.req_width, alloc.req_height));
    end
  end
endmodule

@@ verif/tb_skyline_rect_allocator.sv @@
`timescale 1ns / 100ps
// Top of the allocator bench: clock, reset, request and config stimulus, verdict.
// Depends on sra_pkg, sra_if, sra_tb_pkg and sra_checker.
module tb_skyline_rect_allocator;
  import sra_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [DIM_W-1:0] wr_data;
  int fail_count;
  int pending;
  int idle_cycles;
  bit calm;

  sra_req_if alloc ();
  sra_rsp_if result ();

  skyline_rect_allocator u_dut (
    .clk(clk), .rst(rst), .alloc(alloc), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  sra_checker u_checker (
    .clk(clk), .rst(rst), .alloc(alloc), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side stalls in random bursts
  initial begin
    int n;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((alloc.valid && alloc.ready) || (result.valid && result.ready) || rst)
        idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
        $display("[skyline_rect_allocator] ERROR");
        $finish;
      end
    end
  end

  // valid stays up after acceptance until the next request or an idle gap drops it
  task automatic send_request(logic mode, int w, int h);
    int n;
    wr_en <= 1'b0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 17);
      alloc.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    alloc.valid <= 1'b1;
    alloc.mode <= mode;
    alloc.req_width <= w[DIM_W-1:0];
    alloc.req_height <= h[DIM_W-1:0];
    do @(posedge clk); while (!alloc.ready);
  endtask

  // drop valid, wait for the block to drain, then let any work in flight settle
  task automatic wait_drained();
    alloc.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4 * MAX_SEGMENTS + 20) @(posedge clk);
  endtask

  // write enable is dropped by the next request
  task automatic write_reg(logic idx, int v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v[DIM_W-1:0];
    @(posedge clk);
  endtask

  // mostly small rectangles so the skyline grows many segments
  task automatic random_request(int aw, int ah);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) send_request(1'b1, $urandom_range(0, 8191), $urandom_range(0, 8191));
    else if (r < 6) send_request(1'b0, $urandom_range(0, 8191), $urandom_range(0, 8191));
    else if (r < 10) send_request(1'b0, $urandom_range(0, 1), $urandom_range(0, 3));
    else if (r < 25) send_request(1'b0, $urandom_range(1, aw), $urandom_range(1, ah));
    else send_request(1'b0, $urandom_range(1, (aw > 48) ? aw / 16 : 3),
                      $urandom_range(1, (ah > 48) ? ah / 16 : 3));
  endtask

  initial begin
    int aw, ah;
    calm = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CFG_ATLAS_WIDTH;
    wr_data = '0;
    alloc.valid = 1'b0;
    alloc.mode = 1'b0;
    alloc.req_width = '0;
    alloc.req_height = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset geometry, zero sizes, extremes, full fit, a run of narrow placements
    send_request(1'b0, 0, 5);
    send_request(1'b0, 5, 0);
    send_request(1'b0, 8191, 8191);
    send_request(1'b0, 510, 1);
    send_request(1'b0, 511, 1);
    send_request(1'b0, 1, 1);
    send_request(1'b0, 4096, 4096);
    send_request(1'b1, 8191, 8191);
    send_request(1'b0, 510, 510);
    send_request(1'b0, 1, 1);
    send_request(1'b1, 0, 0);
    for (int k = 0; k < 12; k++) send_request(1'b0, 1 + k % 2, 1 + k);
    wait_drained();

    // tiny and oversized atlases; a register change without clear keeps the skyline
    write_reg(CFG_ATLAS_WIDTH, 3);
    write_reg(CFG_ATLAS_HEIGHT, 3);
    send_request(1'b0, 1, 1);
    send_request(1'b1, 0, 0);
    send_request(1'b0, 1, 1);
    send_request(1'b0, 1, 1);
    wait_drained();
    write_reg(CFG_ATLAS_WIDTH, 2);
    send_request(1'b1, 1, 1);
    send_request(1'b0, 1, 1);
    wait_drained();
    write_reg(CFG_ATLAS_WIDTH, 8191);
    write_reg(CFG_ATLAS_HEIGHT, 8191);
    send_request(1'b1, 1, 1);
    send_request(1'b0, 4094, 4094);
    send_request(1'b0, 4094, 4094);
    wait_drained();

    // random phases over several geometries; narrow atlases fill the table
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin aw = 64; ah = 4096; end
        1: begin aw = 4096; ah = 4096; end
        2: begin aw = 3; ah = 3; end
        default: begin aw = $urandom_range(3, 4096); ah = $urandom_range(3, 4096); end
      endcase
      write_reg(CFG_ATLAS_WIDTH, aw);
      write_reg(CFG_ATLAS_HEIGHT, ah);
      send_request(1'b1, 0, 0);
      if (ph == 7) calm = 1'b1;
      for (int k = 0; k < 125; k++) random_request(aw, ah);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("[skyline_rect_allocator] OK");
    end else begin
      $display("[skyline_rect_allocator] ERROR");
    end
    $finish;
  end
endmodule
